// ===== sv/pssh_ext_pkg.sv =====
package pssh_ext_pkg;

  // Parse phases
  localparam logic [3:0] PH_SIZE32   = 4'd0;
  localparam logic [3:0] PH_TYPE     = 4'd1;
  localparam logic [3:0] PH_SIZE64   = 4'd2;
  localparam logic [3:0] PH_VERSION  = 4'd3;
  localparam logic [3:0] PH_FLAGS    = 4'd4;
  localparam logic [3:0] PH_SYSID    = 4'd5;
  localparam logic [3:0] PH_KIDCOUNT = 4'd6;
  localparam logic [3:0] PH_KIDSKIP  = 4'd7;
  localparam logic [3:0] PH_DATALEN  = 4'd8;
  localparam logic [3:0] PH_DATA     = 4'd9;
  localparam logic [3:0] PH_SKIP     = 4'd10;
  localparam logic [3:0] PH_SKIP_END = 4'd11;

  // Final status codes
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_MALF  = 2'd3;

  localparam logic [31:0] PSSH_TYPE = 32'h7073_7368;

  // Configuration register indexes and reset values
  localparam int unsigned NUM_CFG = 4;
  localparam logic [2:0]  CFG_SYSID_W0 = 3'd0;
  localparam logic [2:0]  CFG_SYSID_W1 = 3'd1;
  localparam logic [2:0]  CFG_SYSID_W2 = 3'd2;
  localparam logic [2:0]  CFG_SYSID_W3 = 3'd3;
  localparam logic [31:0] SYSID_W0_RST = 32'd2584014969;
  localparam logic [31:0] SYSID_W1_RST = 32'd2554348166;
  localparam logic [31:0] SYSID_W2_RST = 32'd2878531163;
  localparam logic [31:0] SYSID_W3_RST = 32'd3767033749;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

// ===== sv/pssh_ext_parser.sv =====
module pssh_ext_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  input  logic [127:0]            sysid,
  output logic                    res_valid,
  output pssh_ext_pkg::result_t   res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] size_r, size_nxt;
  logic [63:0] pos_r, pos_nxt;
  logic [63:0] skip_r, skip_nxt;
  logic        ver1_r, ver1_nxt;
  logic        mism_r, mism_nxt;
  logic        fin_r, fin_nxt;

  logic [63:0] pos_new;
  logic [63:0] acc_sh;
  logic [3:0]  cnt_inc;
  logic [63:0] skip_dec;
  logic [63:0] ss_size;
  logic [63:0] ss_diff;
  logic        ss_end;
  logic        take_skip;
  logic        malformed;
  logic        found;
  logic        have_byte;
  logic        done;
  logic [1:0]  st;
  logic [7:0]  want;
  logic        mm;

  assign acc_sh   = {acc_r[55:0], in_byte};
  assign cnt_inc  = cnt_r + 4'd1;
  assign skip_dec = skip_r - 64'd1;
  assign pos_new  = (phase_r == pssh_ext_pkg::PH_SIZE32 && cnt_r == 4'd0) ?
                    64'd1 : pos_r + 64'd1;
  // Byte k of the wanted ID sits at the top end of the flat vector
  assign want     = sysid[{~cnt_r, 3'b000} +: 8];
  assign mm       = mism_r | (want != in_byte);

  // Size used to resume the walk: the 64-bit size arrives with this byte
  assign ss_size = (phase_r == pssh_ext_pkg::PH_SIZE64) ? acc_sh : size_r;
  assign ss_end  = (phase_r != pssh_ext_pkg::PH_SIZE64) && (skip_r == 64'd1) &&
                   (size_r == 64'd0);
  assign ss_diff = ss_size - pos_new;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    size_nxt  = size_r;
    pos_nxt   = pos_new;
    skip_nxt  = skip_r;
    ver1_nxt  = ver1_r;
    mism_nxt  = mism_r;
    fin_nxt   = fin_r;
    take_skip = 1'b0;
    malformed = 1'b0;
    found     = 1'b0;
    have_byte = 1'b0;
    done      = 1'b0;
    st        = pssh_ext_pkg::ST_BUSY;

    unique case (phase_r)
      pssh_ext_pkg::PH_SIZE32: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd4) begin
          size_nxt  = {32'd0, acc_sh[31:0]};
          skip_nxt  = {63'd0, acc_sh[31:0] == 32'd0};
          phase_nxt = pssh_ext_pkg::PH_TYPE;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      pssh_ext_pkg::PH_TYPE: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd4) begin
          mism_nxt = acc_sh[31:0] != pssh_ext_pkg::PSSH_TYPE;
          cnt_nxt  = '0;
          acc_nxt  = '0;
          if (size_r == 64'd1) begin
            phase_nxt = pssh_ext_pkg::PH_SIZE64;
          end else if (acc_sh[31:0] != pssh_ext_pkg::PSSH_TYPE) begin
            take_skip = 1'b1;
            cnt_nxt   = cnt_inc;
            acc_nxt   = acc_sh;
          end else begin
            phase_nxt = pssh_ext_pkg::PH_VERSION;
          end
        end
      end
      pssh_ext_pkg::PH_SIZE64: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd8) begin
          size_nxt = acc_sh;
          skip_nxt = '0;
          if (mism_r) begin
            take_skip = 1'b1;
          end else begin
            phase_nxt = pssh_ext_pkg::PH_VERSION;
            cnt_nxt   = '0;
            acc_nxt   = '0;
          end
        end
      end
      pssh_ext_pkg::PH_VERSION: begin
        ver1_nxt = in_byte == 8'd1;
        if (in_byte > 8'd1) begin
          take_skip = 1'b1;
        end else begin
          phase_nxt = pssh_ext_pkg::PH_FLAGS;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      pssh_ext_pkg::PH_FLAGS: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd3) begin
          mism_nxt  = 1'b0;
          phase_nxt = pssh_ext_pkg::PH_SYSID;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      pssh_ext_pkg::PH_SYSID: begin
        mism_nxt = mm;
        if (cnt_r == 4'd15) begin
          if (mm) begin
            take_skip = 1'b1;
          end else begin
            phase_nxt = ver1_r ? pssh_ext_pkg::PH_KIDCOUNT : pssh_ext_pkg::PH_DATALEN;
            cnt_nxt   = '0;
            acc_nxt   = '0;
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      pssh_ext_pkg::PH_KIDCOUNT: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd4) begin
          // Sixteen bytes per key ID, no wrap
          skip_nxt  = {28'd0, acc_sh[31:0], 4'd0};
          phase_nxt = (acc_sh[31:0] == 32'd0) ? pssh_ext_pkg::PH_DATALEN :
                                                pssh_ext_pkg::PH_KIDSKIP;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      pssh_ext_pkg::PH_KIDSKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 64'd0) begin
          phase_nxt = pssh_ext_pkg::PH_DATALEN;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      pssh_ext_pkg::PH_DATALEN: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'd4) begin
          skip_nxt = {32'd0, acc_sh[31:0]};
          if (acc_sh[31:0] == 32'd0) begin
            found = 1'b1;
          end else begin
            phase_nxt = pssh_ext_pkg::PH_DATA;
            cnt_nxt   = '0;
            acc_nxt   = '0;
          end
        end
      end
      pssh_ext_pkg::PH_DATA: begin
        have_byte = 1'b1;
        skip_nxt  = skip_dec;
        if (skip_dec == 64'd0) begin
          found = 1'b1;
        end
      end
      pssh_ext_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 64'd0) begin
          phase_nxt = pssh_ext_pkg::PH_SIZE32;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      default: begin
      end
    endcase

    // Resume the walk at the end of the current box
    if (take_skip) begin
      if (ss_end) begin
        phase_nxt = pssh_ext_pkg::PH_SKIP_END;
        cnt_nxt   = '0;
        acc_nxt   = '0;
      end else if (ss_size < pos_new) begin
        malformed = 1'b1;
      end else if (ss_diff == 64'd0) begin
        skip_nxt  = '0;
        phase_nxt = pssh_ext_pkg::PH_SIZE32;
        cnt_nxt   = '0;
        acc_nxt   = '0;
      end else begin
        skip_nxt  = ss_diff;
        phase_nxt = pssh_ext_pkg::PH_SKIP;
        cnt_nxt   = '0;
        acc_nxt   = '0;
      end
    end

    if (malformed || found) begin
      done    = 1'b1;
      st      = malformed ? pssh_ext_pkg::ST_MALF : pssh_ext_pkg::ST_FOUND;
      fin_nxt = 1'b1;
    end else if (in_last) begin
      done = 1'b1;
      st   = ((phase_nxt == pssh_ext_pkg::PH_SIZE32 && cnt_nxt == 4'd0) ||
              phase_nxt == pssh_ext_pkg::PH_SKIP_END) ?
             pssh_ext_pkg::ST_NONE : pssh_ext_pkg::ST_MALF;
    end

    // After the search ends, hold everything until the buffer closes
    if (fin_r) begin
      phase_nxt = phase_r;
      cnt_nxt   = cnt_r;
      acc_nxt   = acc_r;
      size_nxt  = size_r;
      pos_nxt   = pos_r;
      skip_nxt  = skip_r;
      ver1_nxt  = ver1_r;
      mism_nxt  = mism_r;
      have_byte = 1'b0;
      done      = 1'b0;
      st        = pssh_ext_pkg::ST_BUSY;
    end

    // Re-arm on the last byte of the buffer
    if (in_last) begin
      phase_nxt = pssh_ext_pkg::PH_SIZE32;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      size_nxt  = '0;
      pos_nxt   = '0;
      skip_nxt  = '0;
      ver1_nxt  = 1'b0;
      mism_nxt  = 1'b0;
      fin_nxt   = 1'b0;
    end
  end

  assign res_valid        = step & (have_byte | done);
  assign res.payload_byte = have_byte ? in_byte : 8'd0;
  assign res.byte_valid   = have_byte;
  assign res.done_res     = done;
  assign res.status       = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pssh_ext_pkg::PH_SIZE32;
      cnt_r   <= '0;
      acc_r   <= '0;
      size_r  <= '0;
      pos_r   <= '0;
      skip_r  <= '0;
      ver1_r  <= 1'b0;
      mism_r  <= 1'b0;
      fin_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      size_r  <= size_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      ver1_r  <= ver1_nxt;
      mism_r  <= mism_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== sv/pssh_system_header_extractor.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   data_byte[7:0], last_byte
// out_     output     out_valid/out_stall payload_byte[7:0], byte_valid, done_res,
//                                         status[1:0]
// cfg_     input      cfg_wr_en           cfg_index[2:0], cfg_data[31:0]
//
// One byte per cycle sustained while the output is not stalled; a byte's result
// reaches the result register through the input register, then the parse step.
// The parse step is one pass of the header walker over the registered byte.
// Reset is synchronous and active low; it restores the default system ID.
// A stalled result holds the parse step; the input register still takes
// one more transaction while the result waits.
module pssh_system_header_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Wanted system ID, word 0 first
  logic [31:0] sysid_w0_r, sysid_w1_r, sysid_w2_r, sysid_w3_r;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Result register
  logic                  out_valid_r;
  pssh_ext_pkg::result_t out_res_r;

  logic                  out_free;
  logic                  consume;
  logic                  accept;
  logic                  res_valid;
  pssh_ext_pkg::result_t res;

  // The result register frees when empty or when its transaction completes
  assign out_free = !out_valid_r || !out_stall;
  assign consume  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sysid_w0_r <= pssh_ext_pkg::SYSID_W0_RST;
      sysid_w1_r <= pssh_ext_pkg::SYSID_W1_RST;
      sysid_w2_r <= pssh_ext_pkg::SYSID_W2_RST;
      sysid_w3_r <= pssh_ext_pkg::SYSID_W3_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pssh_ext_pkg::CFG_SYSID_W0: sysid_w0_r <= cfg_data;
        pssh_ext_pkg::CFG_SYSID_W1: sysid_w1_r <= cfg_data;
        pssh_ext_pkg::CFG_SYSID_W2: sysid_w2_r <= cfg_data;
        pssh_ext_pkg::CFG_SYSID_W3: sysid_w3_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: load on a transaction, empty once the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (consume) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  pssh_ext_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume),
    .in_byte   (in_byte_r),
    .in_last   (in_last_r),
    .sysid     ({sysid_w0_r, sysid_w1_r, sysid_w2_r, sysid_w3_r}),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: advance whenever it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_byte_valid   = out_res_r.byte_valid;
  assign out_done_res     = out_res_r.done_res;
  assign out_status       = out_res_r.status;

endmodule
